// ===== hdl/device_offline_watchdog_assert.svh =====
// assertion macros used by the watchdog checker
`ifndef DEVICE_OFFLINE_WATCHDOG_ASSERT_SVH
`define DEVICE_OFFLINE_WATCHDOG_ASSERT_SVH

// same-cycle implication, held off during reset
`define DOW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define DOW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dow_pkg.sv =====
// types and constants of the device offline watchdog
`timescale 1ns / 1ps

package dow_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_HEARTBEAT = 2'd1;
  localparam logic [1:0] OP_SCAN      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_OFFLINE_TICKS = 2'd0;
  localparam logic [1:0] REG_ONLINE_TICKS  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_EN    = 2'd2;
  localparam logic [1:0] REG_CHANNEL_PRIO  = 2'd3;

  // configuration reset values
  localparam logic [15:0] OFFLINE_TICKS_RST = 16'd30;
  localparam logic [15:0] ONLINE_TICKS_RST  = 16'd40;
  localparam logic [7:0]  CHANNEL_EN_RST    = 8'd255;
  localparam logic [31:0] CHANNEL_PRIO_RST  = 32'd15;

  // worst channel code for no offline channel
  localparam logic [3:0] NONE_CHANNEL = 4'd8;

  // address width of the time memory request
  localparam int MEM_ADDR_W = 3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] channel;
    logic       data_bad;
  } req_t;

  typedef struct packed {
    logic [7:0] error_mask;
    logic [7:0] lost_mask;
    logic [7:0] offline_mask;
    logic       any_offline;
    logic [3:0] worst_channel;
    logic       data_error_action;
  } rsp_t;

  typedef struct packed {
    logic [15:0] offline_ticks;
    logic [15:0] online_ticks;
    logic [7:0]  channel_enable;
    logic [31:0] channel_priorities;
  } cfg_t;

  typedef struct packed {
    logic [31:0] heard_time;
    logic [31:0] online_since;
  } time_ent_t;

  typedef struct packed {
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] wr_addr;
    time_ent_t             wr_data;
  } mem_req_t;

endpackage

// ===== hdl/dow_time_mem.sv =====
// per-channel time memory: last heartbeat and online-since ticks
`timescale 1ns / 1ps

module dow_time_mem
  import dow_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  mem_req_t  mem_req,
  output time_ent_t rdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  time_ent_t           mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  time_ent_t           rdata_raw;
  logic                rd_hit;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr[CH_W-1:0]] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rdata_raw <= mem[mem_req.rd_addr[CH_W-1:0]];
    end
  end

  // written-entry marks, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (mem_req.wr_en) begin
        valid[mem_req.wr_addr[CH_W-1:0]] <= 1'b1;
      end
      if (mem_req.rd_en) begin
        rd_hit <= valid[mem_req.rd_addr[CH_W-1:0]];
      end
    end
  end

  assign rdata = rd_hit ? rdata_raw : '0;

endmodule

// ===== hdl/dow_seq.sv =====
// request sequencer: tick counter, channel flags and memory scan
`timescale 1ns / 1ps

module dow_seq
  import dow_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_t      req,
  input  cfg_t      cfg,
  input  time_ent_t mem_rdata,
  output mem_req_t  mem_req,
  output logic      busy,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HB_RD,
    S_HB_WR,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [31:0]         tick_now;
  logic [CHANNELS-1:0] lost;
  logic [CHANNELS-1:0] err;
  logic [CHANNELS-1:0] derr;
  logic [CHANNELS-1:0] off_bits;
  logic                aggregate;
  logic [3:0]          worst_index;
  logic [3:0]          worst_prio;
  logic                action;
  logic [CH_W-1:0]     hb_ch;
  logic                hb_bad;
  logic [CH_W-1:0]     scan_idx;
  logic                eval_vld;
  logic [CH_W-1:0]     eval_idx;

  logic [31:0] heard_age;
  logic [31:0] online_age;
  logic        is_off;
  logic        is_unst;
  logic        eval_en;
  logic [3:0]  eval_prio;
  logic        hb_in_range;

  assign busy = (state != S_IDLE);

  // channel classification from the entry read last cycle
  always_comb begin
    heard_age   = tick_now - mem_rdata.heard_time;
    online_age  = tick_now - mem_rdata.online_since;
    is_off      = heard_age > {16'b0, cfg.offline_ticks};
    is_unst     = online_age < {16'b0, cfg.online_ticks};
    eval_en     = cfg.channel_enable[eval_idx];
    eval_prio   = cfg.channel_priorities[4 * eval_idx +: 4];
    hb_in_range = {29'b0, req.channel} < 32'(CHANNELS);
  end

  // memory port: scan reads, heartbeat read-modify-write
  always_comb begin
    mem_req.rd_en   = (state == S_SCAN) || (state == S_HB_RD);
    mem_req.rd_addr = (state == S_SCAN) ? MEM_ADDR_W'(scan_idx) : MEM_ADDR_W'(hb_ch);
    mem_req.wr_en   = (state == S_HB_WR);
    mem_req.wr_addr = MEM_ADDR_W'(hb_ch);
    mem_req.wr_data.heard_time   = tick_now;
    mem_req.wr_data.online_since = lost[hb_ch] ? tick_now : mem_rdata.online_since;
  end

  // state, flags and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tick_now    <= '0;
      lost        <= '0;
      err         <= '0;
      derr        <= '0;
      off_bits    <= '0;
      aggregate   <= 1'b0;
      worst_index <= NONE_CHANNEL;
      worst_prio  <= '0;
      action      <= 1'b0;
      scan_idx    <= '0;
      eval_vld    <= 1'b0;
      eval_idx    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      rsp_valid <= (state == S_FINISH);
      eval_vld  <= (state == S_SCAN);

      // scan evaluation, one channel a cycle
      if (eval_vld && eval_en) begin
        if (is_off) begin
          if (!err[eval_idx]) begin
            lost[eval_idx] <= 1'b1;
            err[eval_idx]  <= 1'b1;
          end
          off_bits[eval_idx] <= 1'b1;
          aggregate          <= 1'b1;
          if (eval_prio > worst_prio) begin
            worst_index <= 4'(eval_idx);
            worst_prio  <= eval_prio;
          end
        end else if (is_unst) begin
          lost[eval_idx] <= 1'b0;
          err[eval_idx]  <= 1'b1;
        end else begin
          lost[eval_idx] <= 1'b0;
          err[eval_idx]  <= derr[eval_idx];
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            off_bits <= '0;
            action   <= 1'b0;
            case (req.opcode)
              OP_TICK: begin
                tick_now <= tick_now + 32'd1;
                state    <= S_FINISH;
              end
              OP_HEARTBEAT: begin
                hb_ch  <= req.channel[CH_W-1:0];
                hb_bad <= req.data_bad;
                state  <= hb_in_range ? S_HB_RD : S_FINISH;
              end
              OP_SCAN: begin
                aggregate   <= 1'b0;
                worst_index <= NONE_CHANNEL;
                worst_prio  <= '0;
                scan_idx    <= '0;
                state       <= S_SCAN;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_HB_RD: begin
          state <= S_HB_WR;
        end
        S_HB_WR: begin
          // entry write happens on the memory port this cycle
          lost[hb_ch] <= 1'b0;
          if (hb_bad) begin
            err[hb_ch]  <= 1'b1;
            derr[hb_ch] <= 1'b1;
            action      <= 1'b1;
          end else begin
            derr[hb_ch] <= 1'b0;
          end
          state <= S_FINISH;
        end
        S_SCAN: begin
          eval_idx <= scan_idx;
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          rsp.error_mask            <= 8'(err);
          rsp.lost_mask             <= 8'(lost);
          rsp.offline_mask          <= 8'(off_bits);
          rsp.any_offline           <= aggregate;
          rsp.worst_channel         <= worst_index;
          rsp.data_error_action     <= action;
          state                     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/device_offline_watchdog.sv =====
// top level of the device offline watchdog
//
//   channel   signals                         direction  handshake
//   request   start, busy, req                in         start && !busy
//   result    rsp_valid, rsp                  out        one-cycle strobe
//   config    cfg_valid, cfg_ready,           in         cfg_valid && cfg_ready
//             cfg_index, cfg_data
//
// tick, unused opcode and out-of-range heartbeat: from accept through the finish state to the result strobe
// heartbeat: read-modify-write of the time memory entry, through the read, write and finish states
// scan: one time memory read per channel, each evaluated in the cycle after its read, then drain and finish
// reset is synchronous: flags, tick counter and memory entry marks clear at once
// the result strobe cannot be stalled; the next request is taken in its cycle
`timescale 1ns / 1ps

module device_offline_watchdog
  import dow_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        rsp_valid,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  mem_req_t  mem_req;
  time_ent_t mem_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offline_ticks      <= OFFLINE_TICKS_RST;
      cfg.online_ticks       <= ONLINE_TICKS_RST;
      cfg.channel_enable     <= CHANNEL_EN_RST;
      cfg.channel_priorities <= CHANNEL_PRIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFFLINE_TICKS: cfg.offline_ticks      <= cfg_data[15:0];
        REG_ONLINE_TICKS:  cfg.online_ticks       <= cfg_data[15:0];
        REG_CHANNEL_EN:    cfg.channel_enable     <= cfg_data[7:0];
        REG_CHANNEL_PRIO:  cfg.channel_priorities <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request sequencer
  dow_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .cfg       (cfg),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // per-channel time memory
  dow_time_mem #(
    .CHANNELS (CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

endmodule

// ===== hdl/dow_checker.sv =====
// port-level checker of the watchdog, bound to the top level
`timescale 1ns / 1ps
`include "device_offline_watchdog_assert.svh"

module dow_checker
  import dow_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic rsp_valid,
  input rsp_t rsp
);

  // a result closes a request: strobe right after the last busy cycle
  `DOW_ASSERT_IMP(a_rsp_after_busy, clk, rst, rsp_valid, !busy && $past(busy), "result without request")

  // an accepted request makes the block busy
  `DOW_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy, "request accepted but not busy")

  // one strobe per request
  `DOW_ASSERT_NXT(a_single_strobe, clk, rst, rsp_valid, !rsp_valid, "result strobe repeated")

  // a chosen worst channel means some channel was offline
  `DOW_ASSERT_IMP(a_worst_offline, clk, rst, rsp_valid && rsp.worst_channel != NONE_CHANNEL, rsp.any_offline, "worst channel without offline flag")

  // an offline channel always carries its error bit
  `DOW_ASSERT_IMP(a_offline_err, clk, rst, rsp_valid, (rsp.offline_mask & ~rsp.error_mask) == 8'd0, "offline channel without error")

endmodule

bind device_offline_watchdog dow_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);
